@@ rtl/core/two_level_page_table_engine_macros.svh @@
// Assertion macros used by the page table engine checker
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define TLPT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlpt check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define TLPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlpt check failed");

`endif

@@ rtl/core/tlpt_pkg.sv @@
// Package: constants, codes and controller/datapath link types of the page table engine
`timescale 1ns / 1ps
`default_nettype none
package tlpt_pkg;

    localparam int DIR_ENTRIES_DEF   = 1024;
    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int TABLE_POOL_DEF    = 16;

    localparam logic [31:0] FLAG_PRESENT  = 32'h0000_0001;
    localparam logic [31:0] FLAG_WRITABLE = 32'h0000_0002;
    localparam logic [31:0] LOW_MASK      = 32'h0000_0FFF;

    // Operation codes
    localparam logic [1:0] OP_TRANSLATE = 2'd0;
    localparam logic [1:0] OP_MAP       = 2'd1;
    localparam logic [1:0] OP_UNMAP     = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_DIR_ABSENT = 2'd1;
    localparam logic [1:0] ST_TBL_ABSENT = 2'd2;
    localparam logic [1:0] ST_NO_TABLE   = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic       in_ready;
        logic       dir_rd;
        logic       ent_rd;
        logic       take_slot;
        logic       alloc;
        logic       clr_dir;
        logic       clr_ent;
        logic       sweep_rst;
        logic       ent_write;
        logic       fin;
        logic       res_ok;
        logic [1:0] status;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       in_valid;
        logic       out_free;
        logic [1:0] op;
        logic       pdi_oob;
        logic       pti_oob;
        logic       dir_present;
        logic       pool_full;
        logic       ent_present;
        logic       dir_sweep_last;
        logic       tbl_sweep_last;
    } sts_t;

endpackage
`default_nettype wire

@@ rtl/core/tlpt_ifs.sv @@
// Interfaces: request and response channels of the page table engine
`timescale 1ns / 1ps
`default_nettype none
interface tlpt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] vaddr;
    logic [31:0] paddr;
    logic [11:0] map_flags;
    logic        use_default_flags;

    modport source (output valid, op, vaddr, paddr, map_flags, use_default_flags,
                    input ready);
    modport sink (input valid, op, vaddr, paddr, map_flags, use_default_flags,
                  output ready);
endinterface

interface tlpt_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] phys_result;
    logic [1:0]  status;

    modport source (output valid, phys_result, status, input ready);
    modport sink (input valid, phys_result, status, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tlpt_ctrl.sv @@
// Controller: sequences directory clear, walks, table allocation and entry updates
`timescale 1ns / 1ps
`default_nettype none
module tlpt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  tlpt_pkg::sts_t sts,
    output tlpt_pkg::cmd_t cmd
);
    import tlpt_pkg::*;

    typedef enum logic [2:0] {
        S_CLR_DIR,
        S_IDLE,
        S_DIR_RD,
        S_DIR_CHK,
        S_CLR_TBL,
        S_ENT_RD,
        S_ENT_CHK
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLR_DIR:
            begin
                cmd.clr_dir = 1'b1;
                if (sts.dir_sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.in_ready = sts.out_free;
                if (sts.out_free && sts.in_valid)
                begin
                    state_next = S_DIR_RD;
                end
            end
            S_DIR_RD:
            begin
                cmd.dir_rd = 1'b1;
                state_next = S_DIR_CHK;
            end
            S_DIR_CHK:
            begin
                state_next = S_IDLE;
                if (sts.op != OP_TRANSLATE && sts.op != OP_MAP && sts.op != OP_UNMAP)
                begin
                    cmd.fin    = 1'b1;
                    cmd.status = ST_OK;
                end
                else if (sts.pdi_oob)
                begin
                    cmd.fin    = 1'b1;
                    cmd.status = ST_DIR_ABSENT;
                end
                else if (sts.op == OP_MAP)
                begin
                    if (sts.pti_oob)
                    begin
                        cmd.fin    = 1'b1;
                        cmd.status = ST_TBL_ABSENT;
                    end
                    else if (sts.dir_present)
                    begin
                        cmd.take_slot = 1'b1;
                        state_next    = S_ENT_RD;
                    end
                    else if (sts.pool_full)
                    begin
                        cmd.fin    = 1'b1;
                        cmd.status = ST_NO_TABLE;
                    end
                    else
                    begin
                        cmd.alloc     = 1'b1;
                        cmd.sweep_rst = 1'b1;
                        state_next    = S_CLR_TBL;
                    end
                end
                else if (!sts.dir_present)
                begin
                    cmd.fin    = 1'b1;
                    cmd.status = ST_DIR_ABSENT;
                end
                else if (sts.pti_oob)
                begin
                    cmd.fin    = 1'b1;
                    cmd.status = ST_TBL_ABSENT;
                end
                else
                begin
                    cmd.take_slot = 1'b1;
                    state_next    = S_ENT_RD;
                end
            end
            S_CLR_TBL:
            begin
                cmd.clr_ent = 1'b1;
                if (sts.tbl_sweep_last)
                begin
                    state_next = S_ENT_RD;
                end
            end
            S_ENT_RD:
            begin
                cmd.ent_rd = 1'b1;
                state_next = S_ENT_CHK;
            end
            S_ENT_CHK:
            begin
                cmd.fin    = 1'b1;
                state_next = S_IDLE;
                if (sts.op == OP_TRANSLATE)
                begin
                    cmd.res_ok = sts.ent_present;
                    cmd.status = sts.ent_present ? ST_OK : ST_TBL_ABSENT;
                end
                else
                begin
                    cmd.ent_write = 1'b1;
                    cmd.status    = ST_OK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR_DIR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/tlpt_datapath.sv @@
// Datapath: item registers, directory and entry memories, table pool and result register
`timescale 1ns / 1ps
`default_nettype none
module tlpt_datapath #(
    parameter int DIR_ENTRIES   = tlpt_pkg::DIR_ENTRIES_DEF,
    parameter int TABLE_ENTRIES = tlpt_pkg::TABLE_ENTRIES_DEF,
    parameter int TABLE_POOL    = tlpt_pkg::TABLE_POOL_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tlpt_pkg::cmd_t cmd,
    output tlpt_pkg::sts_t sts,
    tlpt_req_if.sink       req,
    tlpt_rsp_if.source     rsp
);
    import tlpt_pkg::*;

    localparam int SW     = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
    localparam int DIR_W  = $clog2(DIR_ENTRIES);
    localparam int TE_W   = $clog2(TABLE_ENTRIES);
    localparam int ENT_N  = TABLE_POOL * TABLE_ENTRIES;
    localparam int AW     = $clog2(ENT_N);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int SWP_N  = (DIR_ENTRIES > TABLE_ENTRIES) ? DIR_ENTRIES : TABLE_ENTRIES;
    localparam int SWP_W  = $clog2(SWP_N + 1);
    localparam logic [AW-1:0]    TE_A     = AW'(TABLE_ENTRIES);
    localparam logic [SWP_W-1:0] DIR_LAST = SWP_W'(DIR_ENTRIES - 1);
    localparam logic [SWP_W-1:0] TE_LAST  = SWP_W'(TABLE_ENTRIES - 1);

    // Item registers
    logic [1:0]  op_reg;
    logic [31:0] va_reg;
    logic [31:0] pa_reg;
    logic [11:0] fl_reg;
    logic        def_reg;

    // Memories and pool state
    logic [SW:0]  dir_mem [DIR_ENTRIES];
    logic [31:0]  ent_mem [ENT_N];
    logic [SW:0]  dir_q_reg;
    logic [31:0]  ent_q_reg;
    logic [SW-1:0] slot_reg;
    logic         in_use_reg [TABLE_POOL];
    logic [CNT_W-1:0] live_reg [TABLE_POOL];
    logic [SWP_W-1:0] sweep_reg;

    // Result register
    logic        out_valid_reg;
    logic [31:0] out_res_reg;
    logic [1:0]  out_st_reg;

    logic [9:0]       pdi;
    logic [9:0]       pti;
    logic [DIR_W-1:0] dir_idx;
    logic [AW-1:0]    ent_addr;
    logic [AW-1:0]    clr_addr;
    logic [SW-1:0]    free_slot;
    logic             pool_full;
    logic             load;
    logic             ent_present;
    logic [CNT_W-1:0] cnt_now;
    logic [CNT_W-1:0] cnt_after;
    logic             unmap_free;
    logic [31:0]      map_flags_w;
    logic [31:0]      map_value;
    logic             dir_we;
    logic [DIR_W-1:0] dir_waddr;
    logic [SW:0]      dir_wdata;
    logic             ent_we;
    logic [AW-1:0]    ent_waddr;
    logic [31:0]      ent_wdata;

    assign load     = cmd.in_ready && req.valid;
    assign req.ready = cmd.in_ready;

    assign pdi      = va_reg[31:22];
    assign pti      = va_reg[21:12];
    assign dir_idx  = pdi[DIR_W-1:0];
    assign ent_addr = AW'(slot_reg) * TE_A + AW'(pti[TE_W-1:0]);
    assign clr_addr = AW'(slot_reg) * TE_A + AW'(sweep_reg[TE_W-1:0]);

    // Pick the lowest free table
    always_comb
    begin
        free_slot = '0;
        pool_full = 1'b1;
        for (int i = TABLE_POOL - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_slot = SW'(i);
                pool_full = 1'b0;
            end
        end
    end

    // Work out entry updates
    assign ent_present = ent_q_reg[0];
    assign cnt_now     = live_reg[slot_reg];
    assign cnt_after   = (ent_present && cnt_now != '0) ? cnt_now - CNT_W'(1) : cnt_now;
    assign unmap_free  = cmd.ent_write && (op_reg == OP_UNMAP) && (cnt_after == '0);
    assign map_flags_w = (def_reg ? FLAG_WRITABLE : {20'd0, fl_reg}) | FLAG_PRESENT;
    assign map_value   = (ent_q_reg & LOW_MASK) | (pa_reg & ~LOW_MASK) | map_flags_w;

    // Select the directory write
    always_comb
    begin
        dir_we    = cmd.clr_dir || cmd.alloc || unmap_free;
        dir_waddr = dir_idx;
        dir_wdata = '0;
        if (cmd.clr_dir)
        begin
            dir_waddr = sweep_reg[DIR_W-1:0];
        end
        else if (cmd.alloc)
        begin
            dir_wdata = {1'b1, free_slot};
        end
    end

    // Select the entry write
    always_comb
    begin
        ent_we    = cmd.clr_ent || cmd.ent_write;
        ent_waddr = cmd.clr_ent ? clr_addr : ent_addr;
        ent_wdata = '0;
        if (cmd.ent_write && op_reg == OP_MAP)
        begin
            ent_wdata = map_value;
        end
    end

    // Directory memory
    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        if (cmd.dir_rd)
        begin
            dir_q_reg <= dir_mem[dir_idx];
        end
    end

    // Entry memory
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (cmd.ent_rd)
        begin
            ent_q_reg <= ent_mem[ent_addr];
        end
    end

    // Latch the item and the table slot
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg  <= req.op;
            va_reg  <= req.vaddr;
            pa_reg  <= req.paddr;
            fl_reg  <= req.map_flags;
            def_reg <= req.use_default_flags;
        end
        if (cmd.take_slot)
        begin
            slot_reg <= dir_q_reg[SW-1:0];
        end
        else if (cmd.alloc)
        begin
            slot_reg <= free_slot;
        end
    end

    // Track pool usage and live counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_POOL; i++)
            begin
                in_use_reg[i] <= 1'b0;
                live_reg[i]   <= '0;
            end
        end
        else if (cmd.alloc)
        begin
            in_use_reg[free_slot] <= 1'b1;
            live_reg[free_slot]   <= '0;
        end
        else if (cmd.ent_write)
        begin
            if (op_reg == OP_MAP)
            begin
                if (!ent_present)
                begin
                    live_reg[slot_reg] <= cnt_now + CNT_W'(1);
                end
            end
            else
            begin
                live_reg[slot_reg] <= cnt_after;
                if (cnt_after == '0)
                begin
                    in_use_reg[slot_reg] <= 1'b0;
                end
            end
        end
    end

    // Advance the sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else if (cmd.sweep_rst)
        begin
            sweep_reg <= '0;
        end
        else if (cmd.clr_dir || cmd.clr_ent)
        begin
            sweep_reg <= sweep_reg + SWP_W'(1);
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            out_st_reg  <= cmd.status;
            out_res_reg <= cmd.res_ok ? ((ent_q_reg & ~LOW_MASK) | (va_reg & LOW_MASK)) : '0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.phys_result = out_res_reg;
    assign rsp.status      = out_st_reg;

    // Report status to the controller
    always_comb
    begin
        sts.in_valid       = req.valid;
        sts.out_free       = !out_valid_reg || rsp.ready;
        sts.op             = op_reg;
        sts.pdi_oob        = {1'b0, pdi} >= 11'(DIR_ENTRIES);
        sts.pti_oob        = {1'b0, pti} >= 11'(TABLE_ENTRIES);
        sts.dir_present    = dir_q_reg[SW];
        sts.pool_full      = pool_full;
        sts.ent_present    = ent_present;
        sts.dir_sweep_last = (sweep_reg == DIR_LAST);
        sts.tbl_sweep_last = (sweep_reg == TE_LAST);
    end

endmodule
`default_nettype wire

@@ rtl/core/two_level_page_table_engine.sv @@
// Top level: two-level page table engine with translate, map and unmap
//
// Channels: req (sink) carries op, vaddr, paddr, map_flags and
// use_default_flags; rsp (source) returns phys_result and status. Both use
// valid/ready, a transaction moving on a clock edge with both high.
// One transaction is worked on at a time: a new request is taken only
// once the last one has finished. A request is registered, then the
// directory is read and checked; when that read decides the outcome,
// the result is registered next. A full walk goes on to read and check
// the entry, a second, dependent memory read, before the result is
// registered. When a map allocates a table, the table is first cleared
// one entry a cycle through the single entry memory write port.
// After reset the directory memory is cleared one entry a cycle, and
// req.ready stays low until it is done.
// The result register holds a finished result while rsp.ready is low; a
// new request is taken in the cycle the old result leaves.
`timescale 1ns / 1ps
`default_nettype none
module two_level_page_table_engine #(
    parameter int DIR_ENTRIES   = tlpt_pkg::DIR_ENTRIES_DEF,
    parameter int TABLE_ENTRIES = tlpt_pkg::TABLE_ENTRIES_DEF,
    parameter int TABLE_POOL    = tlpt_pkg::TABLE_POOL_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tlpt_req_if.sink   req,
    tlpt_rsp_if.source rsp
);
    import tlpt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    tlpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    tlpt_datapath #(
        .DIR_ENTRIES   (DIR_ENTRIES),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TABLE_POOL    (TABLE_POOL)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
`default_nettype wire

@@ rtl/core/tlpt_checker.sv @@
// Checker: port-level properties of the page table engine, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "two_level_page_table_engine_macros.svh"
module tlpt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] phys_result,
    input logic [1:0]  status
);
    import tlpt_pkg::*;

    // One transaction at a time: no new request right after one is taken
    `TLPT_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

    // No result can follow a request in the very next cycle
    `TLPT_ASSERT_NEXT(a_no_instant_result, req_valid && req_ready, !rsp_valid)

    // Results with a failed status carry a zero address
    `TLPT_ASSERT_NOW(a_zero_on_error, rsp_valid && status != ST_OK, phys_result == 32'd0)

    // A stalled result holds
    `TLPT_ASSERT_NEXT(a_hold_result, rsp_valid && !rsp_ready, rsp_valid && $stable(phys_result) && $stable(status))

endmodule

bind two_level_page_table_engine tlpt_checker u_tlpt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .phys_result (rsp.phys_result),
    .status      (rsp.status)
);
`default_nettype wire
